### rtl/peer_table_load_balancer_unit_assert.svh
`ifndef PEER_TABLE_LOAD_BALANCER_UNIT_ASSERT_SVH
`define PEER_TABLE_LOAD_BALANCER_UNIT_ASSERT_SVH

// same-cycle implication
`define PTLB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTLB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ptlb_pkg.sv
package ptlb_pkg;

  localparam int unsigned PeerSlotsDefault = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned KW = 5;
  localparam int unsigned ScoreW = 25;

  typedef enum logic [3:0] {
    FN_ADD        = 4'd0,
    FN_REMOVE     = 4'd1,
    FN_SET_STATUS = 4'd2,
    FN_SET_LOAD   = 4'd3,
    FN_SET_CAPS   = 4'd4,
    FN_LOOKUP     = 4'd5,
    FN_LIST_ALIVE = 4'd6,
    FN_LIST_CAP   = 4'd7,
    FN_LEAST      = 4'd8,
    FN_RR         = 4'd9
  } func_e;

  localparam logic [1:0] RC_OK        = 2'd0;
  localparam logic [1:0] RC_FULL      = 2'd1;
  localparam logic [1:0] RC_NOT_FOUND = 2'd2;
  localparam logic [1:0] RC_EMPTY     = 2'd3;

  localparam int unsigned CapIngress = 0;
  localparam int unsigned CapExecute = 1;
  localparam int unsigned CapRoute   = 2;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] node_id;
    logic [31:0] ip_addr;
    logic [15:0] gsp_port;
    logic [15:0] dat_port;
    logic [1:0]  new_status;
    logic [15:0] run_cnt;
    logic [15:0] load_fx;
    logic        ingress_en;
    logic        exec_en;
    logic        route_en;
    logic [7:0]  list_lim;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [31:0] peer_id;
    logic [31:0] peer_ip;
    logic [15:0] peer_gossip_port;
    logic [15:0] peer_data_port;
    logic [1:0]  peer_status;
    logic [15:0] peer_active;
    logic [15:0] peer_load;
    logic        peer_ingress;
    logic        peer_execute;
    logic        peer_route;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] ip;
    logic [15:0] gport;
    logic [15:0] dport;
    logic [1:0]  status;
    logic [15:0] active;
    logic [15:0] load;
    logic [2:0]  caps;
  } entry_t;

  typedef struct packed {
    logic take;
    logic wr_all;
    logic wr_status;
    logic wr_load;
    logic wr_caps;
  } cell_ctl_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_MOD   = 6'b000100,
    ST_PROBE = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

endpackage

### rtl/ptlb_cell.sv
module ptlb_cell (
  input  logic               clk_i,
  input  ptlb_pkg::cell_ctl_t ctl_i,
  input  ptlb_pkg::entry_t   nbr_i,
  input  ptlb_pkg::entry_t   wdata_i,
  output ptlb_pkg::entry_t   entry_o
);
  import ptlb_pkg::*;

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      entry_q <= nbr_i;
    end else begin
      if (ctl_i.wr_all) begin
        entry_q <= wdata_i;
      end
      if (ctl_i.wr_status) begin
        entry_q.status <= wdata_i.status;
      end
      if (ctl_i.wr_load) begin
        entry_q.active <= wdata_i.active;
        entry_q.load   <= wdata_i.load;
      end
      if (ctl_i.wr_caps) begin
        entry_q.caps <= wdata_i.caps;
      end
    end
  end

  assign entry_o = entry_q;

endmodule

### rtl/ptlb_rr_mod.sv
module ptlb_rr_mod #(
  parameter int unsigned PEER_SLOTS = ptlb_pkg::PeerSlotsDefault,
  localparam int unsigned TW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1,
  localparam int unsigned LW = $clog2(PEER_SLOTS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   dividend_i,
  input  logic [LW-1:0] divisor_i,
  output logic          done_o,
  output logic [TW-1:0] rem_o
);
  import ptlb_pkg::*;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [31:0]   sh_q, sh_d;
  logic [LW-1:0] rem_q, rem_d;
  logic [LW-1:0] div_q, div_d;
  logic [LW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    div_d  = div_q;
    trial  = {rem_q, sh_q[31]};
    if (busy_q) begin
      sh_d  = {sh_q[30:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (trial >= {1'b0, div_q}) begin
        rem_d = LW'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[LW-1:0];
      end
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[TW-1:0];

endmodule

### rtl/peer_table_load_balancer_unit.sv
// peer table with least-loaded and round-robin dispatch
// input channel in_valid_i / in_ready_o carries one operation per transfer;
// output channel out_valid_o / out_ready_i carries result items, last marks
// the final result of an operation.
// one operation at a time: in_ready_o is high only while the unit is idle.
// add, remove and set ops pass through the exec and emit states to their result.
// lookup, list and least-loaded rotate the ring of PEER_SLOTS cells once,
// one slot per cycle while the scan is not held by a stalled list result.
// round robin runs a bit-serial modulo of the counter by the
// live count, probes up to live count slots, then, if one is eligible,
// rotates the ring once.
// lists hold the ring while a result waits on a stalled receiver, so a
// stall adds its length to the operation; results are never dropped.
// reset empties the table and clears the round-robin counter; entry
// contents are not cleared, slots past the live count are never read.
module peer_table_load_balancer_unit #(
  parameter int unsigned PEER_SLOTS = ptlb_pkg::PeerSlotsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ptlb_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ptlb_pkg::out_t out_data_o
);
  import ptlb_pkg::*;

  localparam int unsigned TW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int unsigned LW = $clog2(PEER_SLOTS + 1);

  state_e          state_q, state_d;
  in_t             op_q, op_d;
  logic [LW-1:0]   live_q, live_d;
  logic [31:0]     rr_q, rr_d;
  logic [TW-1:0]   t_q, t_d;
  logic [TW-1:0]   tgt_q, tgt_d;
  logic [TW-1:0]   idx_q, idx_d;
  logic [LW-1:0]   tries_q, tries_d;
  logic [PEER_SLOTS-1:0] mvec_q, mvec_d;
  logic [KW-1:0]   k_q, k_d;
  logic [KW-1:0]   cap_q, cap_d;
  logic            found_q, found_d;
  logic [ScoreW-1:0] best_q, best_d;
  out_t            res_q, res_d;
  out_t            out_q, out_d;
  logic            out_valid_q, out_valid_d;

  entry_t          ent [PEER_SLOTS];
  cell_ctl_t       ctl [PEER_SLOTS];
  entry_t          wdata;
  entry_t          head;

  logic [PEER_SLOTS-1:0] hit, cvec, lvec;
  logic            hit_any;
  logic [TW-1:0]   s_idx;
  logic [ScoreW-1:0] score;
  logic            out_free;
  logic            need_emit;
  logic            mod_start, mod_done;
  logic [TW-1:0]   mod_rem;
  out_t            res_init;

  for (genvar g = 0; g < PEER_SLOTS; g++) begin : g_cell
    localparam int unsigned Nx = (g + 1) % PEER_SLOTS;
    ptlb_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl[g]),
      .nbr_i   (ent[Nx]),
      .wdata_i (wdata),
      .entry_o (ent[g])
    );
  end

  ptlb_rr_mod #(.PEER_SLOTS(PEER_SLOTS)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (rr_q),
    .divisor_i  (live_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign head = ent[0];
  assign score = ScoreW'({head.active, 8'h00}) + ScoreW'(head.load) * ScoreW'(10);

  always_comb begin
    for (int i = 0; i < PEER_SLOTS; i++) begin
      hit[i]  = (LW'(i) < live_q) && (ent[i].id == op_q.node_id);
      cvec[i] = (LW'(i) < live_q) && (ent[i].status == 2'd0) && ent[i].caps[CapExecute];
      lvec[i] = (LW'(i) < live_q) && (ent[i].status == 2'd0) &&
                ((op_q.func != FN_LIST_CAP) || (ent[i].caps[CapExecute] == op_q.exec_en));
    end
    hit_any = |hit;
    s_idx   = '0;
    for (int i = PEER_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        s_idx = TW'(i);
      end
    end
  end

  always_comb begin
    wdata.id     = op_q.node_id;
    wdata.ip     = op_q.ip_addr;
    wdata.gport  = op_q.gsp_port;
    wdata.dport  = op_q.dat_port;
    wdata.status = op_q.new_status;
    wdata.active = op_q.run_cnt;
    wdata.load   = op_q.load_fx;
    wdata.caps   = {op_q.route_en, op_q.exec_en, op_q.ingress_en};
    if (op_q.func == FN_ADD) begin
      wdata.status = 2'd0;
      wdata.active = '0;
      wdata.load   = '0;
      wdata.caps   = 3'b110;
    end
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign need_emit = ((op_q.func == FN_LIST_ALIVE) || (op_q.func == FN_LIST_CAP)) &&
                     mvec_q[0] && (k_q < cap_q);

  always_comb begin
    res_init      = '0;
    res_init.last = 1'b1;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    live_d      = live_q;
    rr_d        = rr_q;
    t_d         = t_q;
    tgt_d       = tgt_q;
    idx_d       = idx_q;
    tries_d     = tries_q;
    mvec_d      = mvec_q;
    k_d         = k_q;
    cap_d       = cap_q;
    found_d     = found_q;
    best_d      = best_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mod_start   = 1'b0;
    for (int i = 0; i < PEER_SLOTS; i++) begin
      ctl[i] = '0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_data_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d   = res_init;
        t_d     = '0;
        state_d = ST_EMIT;
        case (op_q.func)
          FN_ADD: begin
            if (hit_any) begin
              res_d.result_code = RC_OK;
            end else if (live_q == LW'(PEER_SLOTS)) begin
              res_d.result_code = RC_FULL;
            end else begin
              for (int i = 0; i < PEER_SLOTS; i++) begin
                if (live_q == LW'(i)) begin
                  ctl[i].wr_all = 1'b1;
                end
              end
              live_d = live_q + LW'(1);
            end
          end
          FN_REMOVE: begin
            if (!hit_any) begin
              res_d.result_code = RC_NOT_FOUND;
            end else begin
              for (int i = 0; i < PEER_SLOTS; i++) begin
                if (TW'(i) >= s_idx) begin
                  ctl[i].take = 1'b1;
                end
              end
              live_d = live_q - LW'(1);
            end
          end
          FN_SET_STATUS, FN_SET_LOAD, FN_SET_CAPS: begin
            if (!hit_any) begin
              res_d.result_code = RC_NOT_FOUND;
            end else begin
              for (int i = 0; i < PEER_SLOTS; i++) begin
                if (TW'(i) == s_idx) begin
                  ctl[i].wr_status = (op_q.func == FN_SET_STATUS);
                  ctl[i].wr_load   = (op_q.func == FN_SET_LOAD);
                  ctl[i].wr_caps   = (op_q.func == FN_SET_CAPS);
                end
              end
            end
          end
          FN_LOOKUP: begin
            if (!hit_any) begin
              res_d.result_code = RC_NOT_FOUND;
            end else begin
              tgt_d   = s_idx;
              state_d = ST_SCAN;
            end
          end
          FN_LIST_ALIVE, FN_LIST_CAP: begin
            k_d    = '0;
            mvec_d = lvec;
            if (op_q.list_lim > 8'(MaxResults)) begin
              cap_d = KW'(MaxResults);
            end else begin
              cap_d = op_q.list_lim[KW-1:0];
            end
            if ((op_q.list_lim == 8'd0) || (lvec == '0)) begin
              res_d.result_code = RC_EMPTY;
            end else begin
              state_d = ST_SCAN;
            end
          end
          FN_LEAST: begin
            mvec_d            = cvec;
            found_d           = 1'b0;
            res_d.result_code = RC_NOT_FOUND;
            state_d           = ST_SCAN;
          end
          FN_RR: begin
            if (live_q == '0) begin
              res_d.result_code = RC_NOT_FOUND;
            end else begin
              mod_start = 1'b1;
              state_d   = ST_MOD;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_MOD: begin
        if (mod_done) begin
          idx_d   = mod_rem;
          tries_d = '0;
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        rr_d = rr_q + 32'd1;
        if (cvec[idx_q]) begin
          tgt_d   = idx_q;
          t_d     = '0;
          state_d = ST_SCAN;
        end else begin
          tries_d = tries_q + LW'(1);
          if ((rr_q == '1) || (LW'(idx_q) == live_q - LW'(1))) begin
            idx_d = '0;
          end else begin
            idx_d = idx_q + TW'(1);
          end
          if (tries_q == live_q - LW'(1)) begin
            res_d.result_code = RC_NOT_FOUND;
            state_d           = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        if (!need_emit || out_free) begin
          for (int i = 0; i < PEER_SLOTS; i++) begin
            ctl[i].take = 1'b1;
          end
          mvec_d = mvec_q >> 1;
          t_d    = t_q + TW'(1);
          case (op_q.func)
            FN_LOOKUP: begin
              if (t_q == tgt_q) begin
                res_d.result_code      = RC_OK;
                res_d.peer_id          = head.id;
                res_d.peer_ip          = head.ip;
                res_d.peer_gossip_port = head.gport;
                res_d.peer_data_port   = head.dport;
                res_d.peer_status      = head.status;
                res_d.peer_active      = head.active;
                res_d.peer_load        = head.load;
                res_d.peer_ingress     = head.caps[CapIngress];
                res_d.peer_execute     = head.caps[CapExecute];
                res_d.peer_route       = head.caps[CapRoute];
              end
            end
            FN_RR: begin
              if (t_q == tgt_q) begin
                res_d.result_code = RC_OK;
                res_d.peer_id     = head.id;
              end
            end
            FN_LEAST: begin
              if (mvec_q[0] && (!found_q || (score < best_q))) begin
                found_d           = 1'b1;
                best_d            = score;
                res_d.result_code = RC_OK;
                res_d.peer_id     = head.id;
              end
            end
            default: begin
              if (need_emit) begin
                out_d             = res_init;
                out_d.result_code = RC_OK;
                out_d.peer_id     = head.id;
                out_d.last        = (k_q + KW'(1) == cap_q) || !(|(mvec_q >> 1));
                out_valid_d       = 1'b1;
                k_d               = k_q + KW'(1);
              end
            end
          endcase
          if (t_q == TW'(PEER_SLOTS - 1)) begin
            if ((op_q.func == FN_LIST_ALIVE) || (op_q.func == FN_LIST_CAP)) begin
              state_d = ST_IDLE;
            end else begin
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      live_q      <= '0;
      rr_q        <= '0;
      t_q         <= '0;
      tries_q     <= '0;
      k_q         <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      rr_q        <= rr_d;
      t_q         <= t_d;
      tries_q     <= tries_d;
      k_q         <= k_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    tgt_q  <= tgt_d;
    idx_q  <= idx_d;
    mvec_q <= mvec_d;
    cap_q  <= cap_d;
    best_q <= best_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/ptlb_checker.sv
`include "peer_table_load_balancer_unit_assert.svh"

module ptlb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input ptlb_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input ptlb_pkg::out_t out_data_o
);
  import ptlb_pkg::*;

  logic in_xfer;
  logic out_stall;
  logic out_err;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_err   = out_valid_o && (out_data_o.result_code != RC_OK);

  `PTLB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o), "stalled result changed")
  `PTLB_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_xfer, !in_ready_o, "ready while an operation runs")
  `PTLB_ASSERT_NOW(a_err_last, clk_i, rst_ni, out_err, out_data_o.last, "error result not last")
  `PTLB_ASSERT_NOW(a_err_id0, clk_i, rst_ni, out_err, out_data_o.peer_id == 32'd0, "error result has id")

endmodule

bind peer_table_load_balancer_unit ptlb_checker u_ptlb_checker (.*);
